@@ rtl/ioc_pkg.sv @@
// ----------------------------------------------------------------------------
// ioc_pkg
// Shared constants, types and microcode table of the interval overlap counter.
// ----------------------------------------------------------------------------
package ioc_pkg;

   localparam int MAX_POSITIONS = 1024;
   localparam int COUNT_BITS    = 20;
   localparam int POS_BITS      = $clog2(MAX_POSITIONS);
   localparam int ADDR_BITS     = POS_BITS + 1;
   localparam int TREE_DEPTH    = 2 * MAX_POSITIONS;
   localparam int FIELD_BITS    = 11;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 24;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;

   localparam logic [FIELD_BITS-1:0]   POSITIONS_RESET = FIELD_BITS'(MAX_POSITIONS);
   localparam logic [CSR_IDX_BITS-1:0] REG_POSITIONS   = CSR_IDX_BITS'(0);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_QRY_RD,
      ST_QRY_ACC,
      ST_QRY_OUT,
      ST_CLEAR
   } step_type;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_DISPATCH,
      C_NOT_ROOT,
      C_NOT_LAST,
      C_OUT_FREE,
      C_CLR_MORE
   } cond_type;

   typedef enum logic {
      RD_NODE,
      RD_SIBLING
   } rdsel_type;

   typedef struct packed {
      logic      accept;
      rdsel_type rd_sel;
      logic      ins_wr;
      logic      qry_acc;
      logic      emit;
      logic      clr_wr;
      cond_type  cond;
      step_type  tgt_a;
      step_type  tgt_b;
   } ucode_type;

   // control store: next step is tgt_a when the condition holds, else tgt_b
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type uw;
      uw = '{accept: 1'b0, rd_sel: RD_NODE, ins_wr: 1'b0, qry_acc: 1'b0,
             emit: 1'b0, clr_wr: 1'b0, cond: C_ALWAYS,
             tgt_a: ST_IDLE, tgt_b: ST_IDLE};
      unique case (step)
         ST_IDLE: begin
            uw.accept = 1'b1;
            uw.cond   = C_DISPATCH;
            uw.tgt_a  = ST_QRY_RD;
            uw.tgt_b  = ST_INS_RD;
         end
         ST_INS_RD: begin
            uw.rd_sel = RD_NODE;
            uw.tgt_a  = ST_INS_WR;
         end
         ST_INS_WR: begin
            uw.ins_wr = 1'b1;
            uw.cond   = C_NOT_ROOT;
            uw.tgt_a  = ST_INS_RD;
            uw.tgt_b  = ST_IDLE;
         end
         ST_QRY_RD: begin
            uw.rd_sel = RD_SIBLING;
            uw.tgt_a  = ST_QRY_ACC;
         end
         ST_QRY_ACC: begin
            uw.qry_acc = 1'b1;
            uw.cond    = C_NOT_LAST;
            uw.tgt_a   = ST_QRY_RD;
            uw.tgt_b   = ST_QRY_OUT;
         end
         ST_QRY_OUT: begin
            uw.emit  = 1'b1;
            uw.cond  = C_OUT_FREE;
            uw.tgt_a = ST_IDLE;
            uw.tgt_b = ST_QRY_OUT;
         end
         ST_CLEAR: begin
            uw.clr_wr = 1'b1;
            uw.cond   = C_CLR_MORE;
            uw.tgt_a  = ST_CLEAR;
            uw.tgt_b  = ST_IDLE;
         end
         default: begin
            uw.tgt_a = ST_IDLE;
         end
      endcase
      return uw;
   endfunction

endpackage

@@ rtl/interval_overlap_counter_top.sv @@
// ----------------------------------------------------------------------------
// interval_overlap_counter_top
// Counts stored intervals that meet a query range, using two sum trees
// walked by a microcoded sequencer.
// ----------------------------------------------------------------------------
// insert: accept, then a read and a write per tree level, 11 levels
// query: sibling read and accumulate per level, result registered in the output step
// both trees are walked in parallel, one read and one write port per tree memory
// the result register holds a word while the next item is accepted
// reset: synchronous; a clearing pass zeroes all 2048 tree entries before the first
// word is accepted, configuration writes are taken during it
module interval_overlap_counter_top
   import ioc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // req_tdata: left_end [10:0], right_end [21:11], zero fill
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // req_tuser: req_type
   input  logic                     req_tuser,
   // rsp_tdata: overlap_count [19:0], zero fill
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam logic [ADDR_BITS-1:0] LEAF_BASE = ADDR_BITS'(MAX_POSITIONS);
   localparam logic [ADDR_BITS-1:0] ROOT      = ADDR_BITS'(1);

   step_type               step_ff, step_in;
   ucode_type              uw;
   logic                   cond_hit, hold;
   logic                   accept, out_free;
   logic                   req_kind;
   logic [FIELD_BITS-1:0]  left_end, right_end, left_m1;

   logic [FIELD_BITS-1:0]  positions_ff, positions_in;
   logic [FIELD_BITS-1:0]  n_eff, s_pos, e_pos;

   logic [ADDR_BITS-1:0]   s_idx_ff, s_idx_in, e_idx_ff, e_idx_in;
   logic                   s_full_ff, s_full_in, e_full_ff, e_full_in;
   logic [COUNT_BITS-1:0]  s_acc_ff, s_acc_in, e_acc_ff, e_acc_in;
   logic [ADDR_BITS-1:0]   clr_ff, clr_in;

   logic [COUNT_BITS-1:0]  start_mem [TREE_DEPTH];
   logic [COUNT_BITS-1:0]  end_mem [TREE_DEPTH];
   logic [COUNT_BITS-1:0]  s_rdata_ff, e_rdata_ff;
   logic [ADDR_BITS-1:0]   s_rd_addr, e_rd_addr, s_wr_addr, e_wr_addr;
   logic [COUNT_BITS-1:0]  s_wr_data, e_wr_data;
   logic                   wr_en;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic                   csr_wr;

   assign left_end  = req_tdata[FIELD_BITS-1:0];
   assign right_end = req_tdata[2*FIELD_BITS-1:FIELD_BITS];
   assign req_kind  = req_tuser;
   assign left_m1   = left_end - FIELD_BITS'(1);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      uw       = ucode_rom(step_ff);
      cond_hit = 1'b1;
      hold     = 1'b0;
      unique case (uw.cond)
         C_ALWAYS: cond_hit = 1'b1;
         C_DISPATCH: begin
            cond_hit = req_kind;
            hold     = !req_tvalid;
         end
         C_NOT_ROOT: cond_hit = (s_idx_ff != ROOT);
         C_NOT_LAST: cond_hit = (s_idx_ff[ADDR_BITS-1:1] != (ADDR_BITS-1)'(1));
         C_OUT_FREE: cond_hit = out_free;
         C_CLR_MORE: cond_hit = (clr_ff != '1);
         default:    cond_hit = 1'b1;
      endcase
      step_in = hold ? step_ff : (cond_hit ? uw.tgt_a : uw.tgt_b);
   end

   assign req_tready = uw.accept;
   assign accept     = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // insert position clamp into 1..n
   always_comb begin
      if (positions_ff == '0) begin
         n_eff = FIELD_BITS'(1);
      end else if (positions_ff > FIELD_BITS'(MAX_POSITIONS)) begin
         n_eff = FIELD_BITS'(MAX_POSITIONS);
      end else begin
         n_eff = positions_ff;
      end
      if (left_end == '0) begin
         s_pos = FIELD_BITS'(1);
      end else if (left_end > n_eff) begin
         s_pos = n_eff;
      end else begin
         s_pos = left_end;
      end
      if (right_end == '0) begin
         e_pos = FIELD_BITS'(1);
      end else if (right_end > n_eff) begin
         e_pos = n_eff;
      end else begin
         e_pos = right_end;
      end
   end

   // tree walk datapath
   always_comb begin
      s_idx_in  = s_idx_ff;
      e_idx_in  = e_idx_ff;
      s_full_in = s_full_ff;
      e_full_in = e_full_ff;
      s_acc_in  = s_acc_ff;
      e_acc_in  = e_acc_ff;
      if (accept) begin
         s_acc_in = '0;
         e_acc_in = '0;
         if (!req_kind) begin
            s_idx_in = ADDR_BITS'(MAX_POSITIONS - 1) + ADDR_BITS'(s_pos);
            e_idx_in = ADDR_BITS'(MAX_POSITIONS - 1) + ADDR_BITS'(e_pos);
         end else begin
            // start prefix up to right_end, end prefix up to left_end - 1
            s_full_in = (right_end >= FIELD_BITS'(MAX_POSITIONS));
            s_idx_in  = s_full_in ? LEAF_BASE
                                  : LEAF_BASE + ADDR_BITS'(right_end[POS_BITS-1:0]);
            e_full_in = (left_end >= FIELD_BITS'(2))
                        && (left_m1 >= FIELD_BITS'(MAX_POSITIONS));
            if (left_end < FIELD_BITS'(2) || e_full_in) begin
               e_idx_in = LEAF_BASE;
            end else begin
               e_idx_in = LEAF_BASE + ADDR_BITS'(left_m1[POS_BITS-1:0]);
            end
         end
      end else if (uw.ins_wr) begin
         s_idx_in = s_idx_ff >> 1;
         e_idx_in = e_idx_ff >> 1;
      end else if (uw.qry_acc) begin
         if (s_full_ff) begin
            s_acc_in = s_rdata_ff;
         end else if (s_idx_ff[0]) begin
            s_acc_in = s_acc_ff + s_rdata_ff;
         end
         if (e_full_ff) begin
            e_acc_in = e_rdata_ff;
         end else if (e_idx_ff[0]) begin
            e_acc_in = e_acc_ff + e_rdata_ff;
         end
         s_idx_in = s_idx_ff >> 1;
         e_idx_in = e_idx_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      s_idx_ff  <= s_idx_in;
      e_idx_ff  <= e_idx_in;
      s_full_ff <= s_full_in;
      e_full_ff <= e_full_in;
      s_acc_ff  <= s_acc_in;
      e_acc_ff  <= e_acc_in;
   end

   // clearing pass counter
   assign clr_in = uw.clr_wr ? clr_ff + ADDR_BITS'(1) : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // tree memories
   always_comb begin
      if (uw.rd_sel == RD_SIBLING) begin
         s_rd_addr = s_full_ff ? ROOT : (s_idx_ff ^ ADDR_BITS'(1));
         e_rd_addr = e_full_ff ? ROOT : (e_idx_ff ^ ADDR_BITS'(1));
      end else begin
         s_rd_addr = s_idx_ff;
         e_rd_addr = e_idx_ff;
      end
      wr_en     = uw.ins_wr | uw.clr_wr;
      s_wr_addr = uw.clr_wr ? clr_ff : s_idx_ff;
      e_wr_addr = uw.clr_wr ? clr_ff : e_idx_ff;
      s_wr_data = uw.clr_wr ? '0 : s_rdata_ff + COUNT_BITS'(1);
      e_wr_data = uw.clr_wr ? '0 : e_rdata_ff + COUNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[s_wr_addr] <= s_wr_data;
      end
      s_rdata_ff <= start_mem[s_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         end_mem[e_wr_addr] <= e_wr_data;
      end
      e_rdata_ff <= end_mem[e_rd_addr];
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;
      if (uw.emit && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = s_acc_ff - e_acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_count_ff);

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr[CSR_ADDR_BITS-1:2] == REG_POSITIONS);
   assign positions_in = csr_wr ? csr_pwdata[FIELD_BITS-1:0] : positions_ff;
   assign csr_prdata   = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_POSITIONS)
                         ? CSR_DATA_BITS'(positions_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         positions_ff <= POSITIONS_RESET;
      end else begin
         positions_ff <= positions_in;
      end
   end

   // assertions
   a_ins_root_done: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_INS_WR && s_idx_ff == ROOT) |=> (step_ff == ST_IDLE))
      else $error("insert walk did not end at the root");

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_CLEAR) |-> !req_tready)
      else $error("word accepted during clearing pass");

   a_rsp_from_out_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(step_ff) == ST_QRY_OUT))
      else $error("result raised outside the output step");

   a_same_tree_level: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_INS_RD || step_ff == ST_INS_WR
       || step_ff == ST_QRY_RD || step_ff == ST_QRY_ACC)
      |-> ((s_idx_ff ^ e_idx_ff) < (s_idx_ff & e_idx_ff)))
      else $error("start and end walks on different tree levels");

endmodule
